// ----- sv/scd_pkg.sv -----
package scd_pkg;

  // Width of every rate value in kHz.
  localparam int KHZ_W = 20;
  localparam int ERR_W = 2;
  localparam int STEP_W = 5;

  // Defaults for the search limits.
  localparam int DEF_PRESCALE_STEPS = 127;
  localparam int DEF_RATE_DIVISOR_MAX = 255;

  // Reset value of the maximum rate register.
  localparam logic [KHZ_W-1:0] MAX_RATE_RESET = 20'd40000;

  // Error codes reported with each result.
  typedef logic [ERR_W-1:0] err_t;
  localparam err_t ERR_OK        = 2'd0;
  localparam err_t ERR_ABOVE_MAX = 2'd1;
  localparam err_t ERR_ZERO_REQ  = 2'd2;
  localparam err_t ERR_NOT_FOUND = 2'd3;

  // Datapath operations selected by the control word.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ERR_ABOVE,
    OP_ERR_ZERO,
    OP_DIV_RATIO,
    OP_LOAD_RATIO,
    OP_DIV_Q,
    OP_LOAD_Q,
    OP_LOAD_S,
    OP_MUL,
    OP_DIV_RATE,
    OP_LOAD_RATE,
    OP_INC_S,
    OP_INC_P,
    OP_ERR_NF,
    OP_SET_OK,
    OP_EMIT
  } dp_op_t;

  // Jump conditions selected by the control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ABOVE_MAX,
    C_ZERO_REQ,
    C_DIV_BUSY,
    C_Q_OUT,
    C_RATE_OK,
    C_S_IN_RANGE,
    C_P_IN_RANGE,
    C_OUT_BLOCKED
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses.
  localparam step_t ST_WAIT     = 5'd0;
  localparam step_t ST_CHK_HI   = 5'd1;
  localparam step_t ST_CHK_ZERO = 5'd2;
  localparam step_t ST_RATIO    = 5'd3;
  localparam step_t ST_RATIO_W  = 5'd4;
  localparam step_t ST_QDIV     = 5'd5;
  localparam step_t ST_QDIV_W   = 5'd6;
  localparam step_t ST_QTEST    = 5'd7;
  localparam step_t ST_MUL      = 5'd8;
  localparam step_t ST_RDIV     = 5'd9;
  localparam step_t ST_RDIV_W   = 5'd10;
  localparam step_t ST_RTEST    = 5'd11;
  localparam step_t ST_INC_S    = 5'd12;
  localparam step_t ST_STEST    = 5'd13;
  localparam step_t ST_NEXT_P   = 5'd14;
  localparam step_t ST_PTEST    = 5'd15;
  localparam step_t ST_NF       = 5'd16;
  localparam step_t ST_FOUND    = 5'd17;
  localparam step_t ST_EMIT     = 5'd18;
  localparam step_t ST_DONE     = 5'd19;

  // One control word: an operation and a conditional jump.
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } uword_t;

  // Flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic no_in;
    logic above_max;
    logic zero_req;
    logic div_busy;
    logic q_out;
    logic rate_ok;
    logic s_in_range;
    logic p_in_range;
    logic out_blocked;
  } status_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [KHZ_W-1:0] dividend;
    logic [KHZ_W-1:0] divisor;
  } div_req_t;

  // Control store of the search program.
  function automatic uword_t ucode(step_t step);
    uword_t w;
    case (step)
      ST_WAIT:     w = '{OP_ACCEPT,     C_NO_IN,       ST_WAIT};
      ST_CHK_HI:   w = '{OP_ERR_ABOVE,  C_ABOVE_MAX,   ST_EMIT};
      ST_CHK_ZERO: w = '{OP_ERR_ZERO,   C_ZERO_REQ,    ST_EMIT};
      ST_RATIO:    w = '{OP_DIV_RATIO,  C_NEVER,       ST_WAIT};
      ST_RATIO_W:  w = '{OP_LOAD_RATIO, C_DIV_BUSY,    ST_RATIO_W};
      ST_QDIV:     w = '{OP_DIV_Q,      C_NEVER,       ST_WAIT};
      ST_QDIV_W:   w = '{OP_LOAD_Q,     C_DIV_BUSY,    ST_QDIV_W};
      ST_QTEST:    w = '{OP_LOAD_S,     C_Q_OUT,       ST_NEXT_P};
      ST_MUL:      w = '{OP_MUL,        C_NEVER,       ST_WAIT};
      ST_RDIV:     w = '{OP_DIV_RATE,   C_NEVER,       ST_WAIT};
      ST_RDIV_W:   w = '{OP_LOAD_RATE,  C_DIV_BUSY,    ST_RDIV_W};
      ST_RTEST:    w = '{OP_NONE,       C_RATE_OK,     ST_FOUND};
      ST_INC_S:    w = '{OP_INC_S,      C_NEVER,       ST_WAIT};
      ST_STEST:    w = '{OP_NONE,       C_S_IN_RANGE,  ST_MUL};
      ST_NEXT_P:   w = '{OP_INC_P,      C_NEVER,       ST_WAIT};
      ST_PTEST:    w = '{OP_NONE,       C_P_IN_RANGE,  ST_QDIV};
      ST_NF:       w = '{OP_ERR_NF,     C_ALWAYS,      ST_EMIT};
      ST_FOUND:    w = '{OP_SET_OK,     C_ALWAYS,      ST_EMIT};
      ST_EMIT:     w = '{OP_EMIT,       C_OUT_BLOCKED, ST_EMIT};
      ST_DONE:     w = '{OP_NONE,       C_ALWAYS,      ST_WAIT};
      default:     w = '{OP_NONE,       C_ALWAYS,      ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/scd_div.sv -----
module scd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  scd_pkg::div_req_t              req,
  output logic                           busy,
  output logic [scd_pkg::KHZ_W-1:0]      quotient
);
  import scd_pkg::*;

  localparam int CNT_W = $clog2(KHZ_W);

  logic [KHZ_W-1:0] rem;
  logic [KHZ_W-1:0] dend;
  logic [KHZ_W-1:0] dsor;
  logic [CNT_W-1:0] count;
  logic [KHZ_W:0]   shifted;
  logic [KHZ_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem, dend[KHZ_W-1]};
  assign diff    = shifted - {1'b0, dsor};
  assign fits    = shifted >= {1'b0, dsor};

  // Busy flag and bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + CNT_W'(1);
      if (count == CNT_W'(KHZ_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  // The remainder stays below the divisor, so it always fits in KHZ_W bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dend <= req.dividend;
      dsor <= req.divisor;
    end else if (busy) begin
      rem      <= fits ? diff[KHZ_W-1:0] : shifted[KHZ_W-1:0];
      dend     <= {dend[KHZ_W-2:0], 1'b0};
      quotient <= {quotient[KHZ_W-2:0], fits};
    end
  end

endmodule

// ----- sv/scd_seq.sv -----
module scd_seq (
  input  logic             clk,
  input  logic             rst,
  input  scd_pkg::status_t status,
  output scd_pkg::dp_op_t  op
);
  import scd_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t word;
  logic   take;

  // Fetch the control word of the current step.
  assign word = ucode(step);
  assign op   = word.op;

  // Evaluate the jump condition.
  always_comb begin
    case (word.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_IN:       take = status.no_in;
      C_ABOVE_MAX:   take = status.above_max;
      C_ZERO_REQ:    take = status.zero_req;
      C_DIV_BUSY:    take = status.div_busy;
      C_Q_OUT:       take = status.q_out;
      C_RATE_OK:     take = status.rate_ok;
      C_S_IN_RANGE:  take = status.s_in_range;
      C_P_IN_RANGE:  take = status.p_in_range;
      C_OUT_BLOCKED: take = status.out_blocked;
      default:       take = 1'b0;
    endcase
    step_next = take ? word.target : step + STEP_W'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- sv/scd_dp.sv -----
module scd_dp #(
  parameter int PRESCALE_STEPS   = scd_pkg::DEF_PRESCALE_STEPS,
  parameter int RATE_DIVISOR_MAX = scd_pkg::DEF_RATE_DIVISOR_MAX
) (
  input  logic                       clk,
  input  logic                       rst,
  input  scd_pkg::dp_op_t            op,
  input  logic                       in_valid,
  input  logic [scd_pkg::KHZ_W-1:0]  request_khz,
  input  logic                       cfg_valid,
  input  logic [scd_pkg::KHZ_W-1:0]  cfg_data,
  input  logic                       div_busy,
  input  logic [scd_pkg::KHZ_W-1:0]  div_quotient,
  output scd_pkg::div_req_t          div_req,
  output scd_pkg::status_t           status,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 prescale_divisor,
  output logic [7:0]                 rate_divisor,
  output logic [scd_pkg::KHZ_W-1:0]  achieved_khz,
  output logic [scd_pkg::ERR_W-1:0]  error_code
);
  import scd_pkg::*;

  localparam int P_W  = $clog2(PRESCALE_STEPS + 2);
  localparam int S_W  = $clog2(RATE_DIVISOR_MAX + 2);
  localparam int PR_W = P_W + S_W;

  logic [KHZ_W-1:0] max_rate;
  logic [KHZ_W-1:0] req;
  logic [KHZ_W-1:0] ratio;
  logic [KHZ_W-1:0] q;
  logic [KHZ_W-1:0] rate;
  logic [P_W-1:0]   p;
  logic [S_W-1:0]   s;
  logic [PR_W-1:0]  prod;
  err_t             err;
  logic             emit_ok;

  // Maximum rate register, written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate <= MAX_RATE_RESET;
    end else if (cfg_valid) begin
      max_rate <= cfg_data;
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT:     if (in_valid) req <= request_khz;
      OP_ERR_ABOVE:  err <= ERR_ABOVE_MAX;
      OP_ERR_ZERO:   err <= ERR_ZERO_REQ;
      OP_DIV_RATIO:  p <= P_W'(1);
      OP_LOAD_RATIO: ratio <= div_quotient;
      OP_LOAD_Q:     q <= div_quotient;
      OP_LOAD_S:     s <= S_W'(q - KHZ_W'(1));
      OP_MUL:        prod <= PR_W'(p) * PR_W'(s + S_W'(1));
      OP_LOAD_RATE:  rate <= div_quotient;
      OP_INC_S:      s <= s + S_W'(1);
      OP_INC_P:      p <= p + P_W'(1);
      OP_ERR_NF:     err <= ERR_NOT_FOUND;
      OP_SET_OK:     err <= ERR_OK;
      default:       ;
    endcase
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = max_rate;
    div_req.divisor  = req;
    case (op)
      OP_DIV_RATIO: div_req.start = 1'b1;
      OP_DIV_Q: begin
        div_req.start    = 1'b1;
        div_req.dividend = ratio;
        div_req.divisor  = KHZ_W'(p);
      end
      OP_DIV_RATE: begin
        div_req.start   = 1'b1;
        div_req.divisor = KHZ_W'(prod);
      end
      default: ;
    endcase
  end

  // Flags for the sequencer's jump conditions.
  always_comb begin
    status.no_in       = !in_valid;
    status.above_max   = req > max_rate;
    status.zero_req    = req == '0;
    status.div_busy    = div_busy;
    status.q_out       = (q == '0) || (q > KHZ_W'(RATE_DIVISOR_MAX + 1));
    status.rate_ok     = rate <= req;
    status.s_in_range  = s <= S_W'(RATE_DIVISOR_MAX);
    status.p_in_range  = p <= P_W'(PRESCALE_STEPS);
    status.out_blocked = out_valid && out_stall;
  end

  assign emit_ok = (op == OP_EMIT) && !(out_valid && out_stall);

  // Output register: holds a finished result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields; the divisors and achieved rate are zero unless a divisor pair was found.
  always_ff @(posedge clk) begin
    if (emit_ok) begin
      error_code <= err;
      if (err == ERR_OK) begin
        prescale_divisor <= 8'({p, 1'b0});
        rate_divisor     <= 8'(s);
        achieved_khz     <= rate;
      end else begin
        prescale_divisor <= '0;
        rate_divisor     <= '0;
        achieved_khz     <= '0;
      end
    end
  end

endmodule

// ----- sv/serial_clock_divider_search.sv -----
// Each skipped prescale step and each further rate divisor trial lengthens the search.
// Requests above the maximum rate or of zero skip the search and go straight to the emit step.
// Throughput: one request at a time; the shared divider sets the pace.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) restarts the program, empties the output
// register, idles the divider and sets max_rate back to 40000.
module serial_clock_divider_search #(
  parameter int PRESCALE_STEPS   = scd_pkg::DEF_PRESCALE_STEPS,
  parameter int RATE_DIVISOR_MAX = scd_pkg::DEF_RATE_DIVISOR_MAX
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [scd_pkg::KHZ_W-1:0]  request_khz,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scd_pkg::KHZ_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 prescale_divisor,
  output logic [7:0]                 rate_divisor,
  output logic [scd_pkg::KHZ_W-1:0]  achieved_khz,
  output logic [scd_pkg::ERR_W-1:0]  error_code
);
  import scd_pkg::*;

  dp_op_t           op;
  status_t          status;
  div_req_t         div_req;
  logic             div_busy;
  logic [KHZ_W-1:0] div_quotient;

  // A request transfers only in the program's wait step.
  assign in_stall  = op != OP_ACCEPT;
  assign cfg_ready = 1'b1;

  // Program sequencer.
  scd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // Search datapath and output register.
  scd_dp #(
    .PRESCALE_STEPS   (PRESCALE_STEPS),
    .RATE_DIVISOR_MAX (RATE_DIVISOR_MAX)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .in_valid         (in_valid),
    .request_khz      (request_khz),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .div_busy         (div_busy),
    .div_quotient     (div_quotient),
    .div_req          (div_req),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .prescale_divisor (prescale_divisor),
    .rate_divisor     (rate_divisor),
    .achieved_khz     (achieved_khz),
    .error_code       (error_code)
  );

  // Shared divider.
  scd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

endmodule
